// ----- sv/rla_pkg.sv -----
// ============================================================================
// rla_pkg - shared definitions for the running LCM accumulator
// Field widths, datapath types, sequencer state codes and output saturation.
// ============================================================================
package rla_pkg;

    // Width of a task period and of the running LCM register.
    localparam int PERIOD_WIDTH = 16;
    localparam int LCM_WIDTH    = 32;

    // The hyperperiod port is always 32 bits wide.
    localparam int HP_WIDTH = 32;

    // Width used when comparing the running LCM against the port maximum.
    localparam int EXT_WIDTH = (LCM_WIDTH > HP_WIDTH) ? LCM_WIDTH : HP_WIDTH;

    // Divider bit counter, GCD factor-of-two counter and full product width.
    localparam int DIV_CNT_WIDTH = $clog2(LCM_WIDTH + 1);
    localparam int GCD_K_WIDTH   = $clog2(PERIOD_WIDTH + 1);
    localparam int PROD_WIDTH    = LCM_WIDTH + PERIOD_WIDTH;

    typedef logic [PERIOD_WIDTH-1:0] t_period;
    typedef logic [LCM_WIDTH-1:0]    t_lcm;
    typedef logic [HP_WIDTH-1:0]     t_hp;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MOD  = 6'b000010,
        ST_GCD  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    // Clamp the running LCM to the width of the output port.
    function automatic t_hp sat_hp(input t_lcm v);
        logic [EXT_WIDTH-1:0] ext;
        logic [EXT_WIDTH-1:0] hp_max;
        ext    = EXT_WIDTH'(v);
        hp_max = EXT_WIDTH'({HP_WIDTH{1'b1}});
        if (ext > hp_max) begin
            return '1;
        end
        return ext[HP_WIDTH-1:0];
    endfunction

endpackage

// ----- sv/rla_div.sv -----
// ============================================================================
// rla_div - bit-serial restoring divider
// Divides an LCM-wide dividend by a period-wide divisor, one quotient bit
// per cycle, giving quotient and remainder.
// ============================================================================
module rla_div
    import rla_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_lcm    i_dividend,
    input  t_period i_divisor,
    output logic    o_done,
    output t_lcm    o_quotient,
    output t_period o_remainder
);

    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    logic [DIV_CNT_WIDTH-1:0] r_cnt,  n_cnt;
    t_lcm                     r_quo,  n_quo;
    t_period                  r_rem,  n_rem;
    t_period                  r_dvs,  n_dvs;
    logic [PERIOD_WIDTH:0]    trial;
    logic [PERIOD_WIDTH:0]    diff;
    logic                     fits;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign trial = {r_rem, r_quo[LCM_WIDTH-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_WIDTH'(LCM_WIDTH);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[LCM_WIDTH-2:0], fits};
            n_rem = fits ? diff[PERIOD_WIDTH-1:0] : trial[PERIOD_WIDTH-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_WIDTH'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ----- sv/rla_gcd.sv -----
// ============================================================================
// rla_gcd - binary greatest common divisor
// Shift-and-subtract GCD of two period-wide values; the first operand must
// be nonzero. One halving or one subtraction per cycle.
// ============================================================================
module rla_gcd
    import rla_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_period i_a,
    input  t_period i_b,
    output logic    o_done,
    output t_period o_gcd
);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    t_period                r_a,    n_a;
    t_period                r_b,    n_b;
    logic [GCD_K_WIDTH-1:0] r_k,    n_k;
    t_period                r_g,    n_g;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_a    = r_a;
        n_b    = r_b;
        n_k    = r_k;
        n_g    = r_g;
        if (i_start) begin
            n_busy = 1'b1;
            n_a    = i_a;
            n_b    = i_b;
            n_k    = '0;
        end else if (r_busy) begin
            if (r_b == '0) begin
                // Restore the common factors of two removed on the way.
                n_g    = r_a << r_k;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (!r_a[0] && !r_b[0]) begin
                n_a = r_a >> 1;
                n_b = r_b >> 1;
                n_k = r_k + 1'b1;
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (r_a >= r_b) begin
                // Keep the smaller odd value and carry on with the difference.
                n_a = r_b;
                n_b = r_a - r_b;
            end else begin
                n_b = r_b - r_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_k <= n_k;
        r_g <= n_g;
    end

    assign o_done = r_done;
    assign o_gcd  = r_g;

endmodule

// ----- sv/rla_mul.sv -----
// ============================================================================
// rla_mul - shift-and-add multiplier with range check
// Multiplies an LCM-wide value by a period, one multiplier bit per cycle,
// and flags a product that does not fit the LCM width.
// ============================================================================
module rla_mul
    import rla_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_lcm    i_mcand,
    input  t_period i_mplier,
    output logic    o_done,
    output t_lcm    o_product,
    output logic    o_overflow
);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [PROD_WIDTH-1:0] r_acc,  n_acc;
    logic [PROD_WIDTH-1:0] r_mc,   n_mc;
    t_period               r_mp,   n_mp;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_acc  = r_acc;
        n_mc   = r_mc;
        n_mp   = r_mp;
        if (i_start) begin
            n_busy = 1'b1;
            n_acc  = '0;
            n_mc   = PROD_WIDTH'(i_mcand);
            n_mp   = i_mplier;
        end else if (r_busy) begin
            if (r_mp[0]) begin
                n_acc = r_acc + r_mc;
            end
            n_mc = r_mc << 1;
            n_mp = r_mp >> 1;
            // Stop as soon as no multiplier bits remain.
            if (n_mp == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_mc  <= n_mc;
        r_mp  <= n_mp;
    end

    assign o_done     = r_done;
    assign o_product  = r_acc[LCM_WIDTH-1:0];
    assign o_overflow = |r_acc[PROD_WIDTH-1:LCM_WIDTH];

endmodule

// ----- sv/running_lcm_accumulator_core.sv -----
// ============================================================================
// running_lcm_accumulator_core - running hyperperiod of a task set
// Folds task periods into a running least common multiple, saturating with a
// sticky overflow flag when the result no longer fits.
// ============================================================================
// The input channel (i_valid, o_stall, i_period, i_first) takes one word per
// period; i_first restarts the accumulation and a zero period counts as one.
// Each input word gives exactly one output word (o_valid, i_stall,
// o_hyperperiod, o_overflow), in order. o_stall is high from acceptance until
// the result sits in the output register. The bit-serial work is a reduction
// modulo the period, a binary GCD, a division by the GCD and a multiplication
// by the period; the next word can be taken in the cycle in which o_valid
// rises. Once overflow is set, words up to the next restart skip the
// arithmetic and go from ST_IDLE through ST_OUT to the output register. While
// i_stall holds the output word, the next input word is still taken and its
// result waits. Synchronous reset sets the running LCM to one and clears
// overflow.
// ============================================================================
module running_lcm_accumulator_core
    import rla_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_period i_period,
    input  logic    i_first,
    output logic    o_valid,
    input  logic    i_stall,
    output t_hp     o_hyperperiod,
    output logic    o_overflow
);

    t_state  r_state, n_state;
    t_lcm    r_lcm,   n_lcm;
    logic    r_ovf,   n_ovf;
    t_period r_p,     n_p;
    logic    r_out_valid, n_out_valid;
    t_hp     r_out_hp,    n_out_hp;
    logic    r_out_ovf,   n_out_ovf;

    logic    in_accept;
    t_period p_in;
    t_lcm    cur_in;
    logic    ovf_in;

    logic    div_start, div_done;
    t_lcm    div_dividend, div_quo;
    t_period div_divisor, div_rem;
    logic    gcd_start, gcd_done;
    t_period gcd_g;
    logic    mul_start, mul_done, mul_ovf;
    t_lcm    mul_prod;
    logic    out_free;

    assign o_stall   = (r_state != ST_IDLE);
    assign in_accept = i_valid && !o_stall;

    // A zero period leaves the LCM alone, so it is taken as one. A restart
    // begins from a running value of one with overflow cleared.
    assign p_in   = (i_period == '0) ? t_period'(1) : i_period;
    assign cur_in = (i_first || r_lcm == '0) ? t_lcm'(1) : r_lcm;
    assign ovf_in = i_first ? 1'b0 : r_ovf;

    // The output register can be loaded when empty or when it is being read.
    assign out_free = !r_out_valid || !i_stall;

    // The divider is shared: first it reduces the running value modulo the
    // period, later it divides the running value by the GCD.
    assign div_start    = (in_accept && !ovf_in) || (r_state == ST_GCD && gcd_done);
    assign div_dividend = (r_state == ST_IDLE) ? cur_in : r_lcm;
    assign div_divisor  = (r_state == ST_IDLE) ? p_in : gcd_g;
    assign gcd_start    = (r_state == ST_MOD) && div_done;
    assign mul_start    = (r_state == ST_DIV) && div_done;

    rla_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    rla_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gcd_start),
        .i_a     (r_p),
        .i_b     (div_rem),
        .o_done  (gcd_done),
        .o_gcd   (gcd_g)
    );

    rla_mul u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mul_start),
        .i_mcand    (div_quo),
        .i_mplier   (r_p),
        .o_done     (mul_done),
        .o_product  (mul_prod),
        .o_overflow (mul_ovf)
    );

    // Sequencer: reduce, GCD, divide, multiply, then hand the word over.
    always_comb begin
        n_state     = r_state;
        n_lcm       = r_lcm;
        n_ovf       = r_ovf;
        n_p         = r_p;
        n_out_valid = r_out_valid && i_stall;
        n_out_hp    = r_out_hp;
        n_out_ovf   = r_out_ovf;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_lcm   = cur_in;
                    n_ovf   = ovf_in;
                    n_p     = p_in;
                    // A saturated value stays put until the next restart.
                    n_state = ovf_in ? ST_OUT : ST_MOD;
                end
            end
            ST_MOD: begin
                if (div_done) begin
                    n_state = ST_GCD;
                end
            end
            ST_GCD: begin
                if (gcd_done) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    if (mul_ovf) begin
                        n_lcm = '1;
                        n_ovf = 1'b1;
                    end else begin
                        n_lcm = mul_prod;
                    end
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hp    = sat_hp(r_lcm);
                    n_out_ovf   = r_ovf;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lcm       <= t_lcm'(1);
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lcm       <= n_lcm;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p       <= n_p;
        r_out_hp  <= n_out_hp;
        r_out_ovf <= n_out_ovf;
    end

    assign o_valid       = r_out_valid;
    assign o_hyperperiod = r_out_hp;
    assign o_overflow    = r_out_ovf;

endmodule
